@@ design/mbe_pkg.sv @@
// Package for the fixed-point Mandelbrot escape-time unit.
// Holds the request and result types, controller codes, and word helpers.
// Depends on nothing.
`default_nettype none

package mbe_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = 12;
	localparam int CNT_W      = 8;
	localparam int BAND_W     = 3;
	localparam int PROD_W     = 2 * DATA_WIDTH - 1;

	localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(32);
	localparam logic [CNT_W-1:0] THRESH_1    = CNT_W'(4);
	localparam logic [CNT_W-1:0] THRESH_2    = CNT_W'(8);
	localparam logic [CNT_W-1:0] THRESH_3    = CNT_W'(16);

	localparam logic [BAND_W-1:0] BAND_SHORT  = BAND_W'(0);
	localparam logic [BAND_W-1:0] BAND_MEDIUM = BAND_W'(1);
	localparam logic [BAND_W-1:0] BAND_LONG   = BAND_W'(2);
	localparam logic [BAND_W-1:0] BAND_SLOW   = BAND_W'(3);
	localparam logic [BAND_W-1:0] BAND_INSIDE = BAND_W'(4);

	typedef logic [DATA_WIDTH-1:0] word_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] c_real;
		logic signed [DATA_WIDTH-1:0] c_imag;
	} req_t;

	typedef struct packed {
		logic [CNT_W-1:0]  iteration_count;
		logic [BAND_W-1:0] color_band;
		logic              escaped;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RR,
		ST_II,
		ST_CROSS,
		ST_UPDATE,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		MUL_RR,
		MUL_II,
		MUL_CROSS
	} mul_op_t;

	typedef struct packed {
		logic    load;
		mul_op_t op;
		logic    take_rr;
		logic    take_ii;
		logic    update;
	} cmd_t;

	typedef struct packed {
		logic finish;
	} sts_t;

	function automatic word_t wneg(input word_t x);
		return ~x + word_t'(1);
	endfunction

	function automatic logic in_escape(input word_t x);
		return !x[DATA_WIDTH-1] && (x[DATA_WIDTH-2:DATA_WIDTH-3] != 2'b00);
	endfunction

endpackage

`default_nettype wire

@@ design/mbe_ctrl.sv @@
// Controller state machine for the Mandelbrot escape-time unit.
// Sequences the three shared multiplies and the update of each iteration.
// Depends on mbe_pkg.
`default_nettype none

module mbe_ctrl
	import mbe_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  sts_t   sts,
	output cmd_t   cmd,
	output logic   busy,
	output logic   done
);

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx    = state_q;
		cmd.load    = 1'b0;
		cmd.op      = MUL_RR;
		cmd.take_rr = 1'b0;
		cmd.take_ii = 1'b0;
		cmd.update  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nx  = ST_RR;
				end
			end
			ST_RR: begin
				cmd.op   = MUL_RR;
				state_nx = ST_II;
			end
			ST_II: begin
				cmd.op      = MUL_II;
				cmd.take_rr = 1'b1;
				state_nx    = ST_CROSS;
			end
			ST_CROSS: begin
				cmd.op      = MUL_CROSS;
				cmd.take_ii = 1'b1;
				state_nx    = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_nx   = sts.finish ? ST_DONE : ST_RR;
			end
			ST_DONE: begin
				state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

endmodule

`default_nettype wire

@@ design/mbe_datapath.sv @@
// Datapath for the Mandelbrot escape-time unit: z and c registers, one
// shared sign-magnitude multiplier, update adders, escape test and banding.
// Depends on mbe_pkg.
`default_nettype none

module mbe_datapath
	import mbe_pkg::*;
(
	input  logic             clk,
	input  cmd_t             cmd,
	input  req_t             request,
	input  logic [CNT_W-1:0] limit,
	output sts_t             sts,
	output rsp_t             result
);

	word_t              cr_q, ci_q, zr_q, zi_q, rr_q, ii_q;
	logic [PROD_W-1:0]  prod_q;
	logic               neg_q;
	logic [CNT_W-1:0]   count_q;
	logic               esc_q;

	word_t                       op_a, op_b, mag_a, mag_b_full;
	logic [DATA_WIDTH-2:0]       mag_b;
	logic [PROD_W+FRAC_BITS-1:0] prod_ext;
	word_t                       prod_slice, prod_val;
	word_t                       zr_nx, zi_nx;
	logic [CNT_W-1:0]            count_nx;
	logic                        esc_nx;

	always_comb begin
		case (cmd.op)
			MUL_RR: begin
				op_a = zr_q;
				op_b = zr_q;
			end
			MUL_II: begin
				op_a = zi_q;
				op_b = zi_q;
			end
			MUL_CROSS: begin
				op_a = {zi_q[DATA_WIDTH-2:0], 1'b0};
				op_b = zr_q;
			end
			default: begin
				op_a = zr_q;
				op_b = zr_q;
			end
		endcase
	end

	assign mag_a      = op_a[DATA_WIDTH-1] ? wneg(op_a) : op_a;
	assign mag_b_full = op_b[DATA_WIDTH-1] ? wneg(op_b) : op_b;
	assign mag_b      = mag_b_full[DATA_WIDTH-2:0];

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mag_a) * PROD_W'(mag_b);
		neg_q  <= op_a[DATA_WIDTH-1] ^ op_b[DATA_WIDTH-1];
	end

	assign prod_ext   = {{FRAC_BITS{1'b0}}, prod_q};
	assign prod_slice = prod_ext[FRAC_BITS+DATA_WIDTH-1:FRAC_BITS];
	assign prod_val   = neg_q ? wneg(prod_slice) : prod_slice;

	assign zi_nx    = prod_val + ci_q;
	assign zr_nx    = rr_q - ii_q + cr_q;
	assign count_nx = count_q + CNT_W'(1);
	assign esc_nx   = in_escape(zr_nx) || in_escape(wneg(zr_nx)) ||
	                  in_escape(zi_nx) || in_escape(wneg(zi_nx));

	assign sts.finish = esc_nx || (count_nx >= limit);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cr_q    <= word_t'(request.c_real);
			ci_q    <= word_t'(request.c_imag);
			zr_q    <= '0;
			zi_q    <= '0;
			count_q <= '0;
			esc_q   <= 1'b0;
		end
		if (cmd.take_rr) begin
			rr_q <= prod_val;
		end
		if (cmd.take_ii) begin
			ii_q <= prod_val;
		end
		if (cmd.update) begin
			zr_q    <= zr_nx;
			zi_q    <= zi_nx;
			count_q <= count_nx;
			esc_q   <= esc_nx;
		end
	end

	always_comb begin
		result.iteration_count = count_q;
		result.escaped         = esc_q;
		if (count_q < THRESH_1) begin
			result.color_band = BAND_SHORT;
		end else if (count_q < THRESH_2) begin
			result.color_band = BAND_MEDIUM;
		end else if (count_q < THRESH_3) begin
			result.color_band = BAND_LONG;
		end else if (count_q < limit) begin
			result.color_band = BAND_SLOW;
		end else begin
			result.color_band = BAND_INSIDE;
		end
	end

endmodule

`default_nettype wire

@@ design/mandelbrot_escape_q4_12.sv @@
// Mandelbrot escape-time unit, Q4.12 points; top level with the limit register.
// Each iteration steps through the RR, II, CROSS and update states on the one shared
// multiplier; a point's result shows in the done state, and busy stays high while
// the result is shown, so a new point can start only once busy has fallen.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
// Reset clears the controller to idle and sets the iteration limit to 32.
`default_nettype none

module mandelbrot_escape_q4_12
	import mbe_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  req_t             request,
	output logic             done,
	output rsp_t             result,
	input  logic             limit_we,
	input  logic [CNT_W-1:0] limit_wdata
);

	logic [CNT_W-1:0] limit_q;
	cmd_t             cmd;
	sts_t             sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (limit_we) begin
			limit_q <= limit_wdata;
		end
	end

	mbe_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	mbe_datapath u_datapath (
		.clk     (clk),
		.cmd     (cmd),
		.request (request),
		.limit   (limit_q),
		.sts     (sts),
		.result  (result)
	);

endmodule

`default_nettype wire
